@@ hw/rtl/device_address_table_assert.svh @@
// Assertion macros for the address table RTL, included by its top level.
`ifndef DEVICE_ADDRESS_TABLE_ASSERT_SVH
`define DEVICE_ADDRESS_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define DAT_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("address table assertion failed");
`define DAT_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("address table assertion failed");
`else
`define DAT_ASSERT_IMPLY(name, clk, rst_n, pre, post)
`define DAT_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

@@ hw/rtl/dat_pkg.sv @@
package dat_pkg;

	localparam int DEFAULT_DEPTH = 32;
	localparam int ADDR_W        = 48;
	localparam int MARK_W        = 2;
	localparam int ENTRY_W       = ADDR_W + 2 * MARK_W;
	localparam int KIND_W        = 2;
	localparam int STATUS_W      = 3;
	localparam int COUNT_OUT_W   = 6;

	typedef enum logic [KIND_W-1:0] {
		K_CLEAR   = 2'd0,
		K_ADD     = 2'd1,
		K_RESTART = 2'd2,
		K_NEXT    = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_PRESENT   = 3'd2,
		ST_FULL      = 3'd3,
		ST_ENTRY     = 3'd4,
		ST_EXHAUSTED = 3'd5
	} status_t;

	localparam logic [MARK_W-1:0] MARK_NO   = 2'd0;
	localparam logic [MARK_W-1:0] MARK_YES  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_BOTH = 2'd2;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

@@ hw/rtl/device_address_table.sv @@
// Table of seen device addresses, kept in insertion order with two marks per entry.
// A request is taken at a rising edge where start is high and busy is low; kind selects
// clear, add, restart enumeration or enumerate next. Every request produces exactly one
// result, shown on the result ports for a single cycle while strobe is high.
// Clear and restart report one cycle after the request is taken, and so does an
// enumerate-next that finds nothing left. An enumerate-next that returns an entry
// passes through the fetch state before it reports, as it waits on one read of the table memory.
// An add walks the stored entries one per cycle through the single read port of the
// table memory, comparing each entry once its read returns: a match reports at its entry,
// and an absent address once all entries are compared (at once on an empty table).
// Busy falls in the cycle that carries the result, so the next request may be taken then.
// Only one request is worked on at a time.
// Reset empties the table and rewinds the enumeration cursor at once; the memory itself
// is not swept, as entries at or beyond the count are never read.
// The receiver cannot hold results off, so nothing is ever stalled on the output side.
`include "device_address_table_assert.svh"

module device_address_table #(
	parameter int TABLE_DEPTH = dat_pkg::DEFAULT_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [dat_pkg::KIND_W-1:0]          kind,
	input  logic [dat_pkg::ADDR_W-1:0]          device_address,
	input  logic                                is_connectable,
	input  logic                                is_public,
	output logic                                strobe,
	output logic [dat_pkg::STATUS_W-1:0]        status,
	output logic [dat_pkg::ADDR_W-1:0]          entry_address,
	output logic [dat_pkg::MARK_W-1:0]          connect_mark,
	output logic [dat_pkg::MARK_W-1:0]          public_mark,
	output logic [dat_pkg::COUNT_OUT_W-1:0]     entry_count
);
	import dat_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);

	mem_ctl_t           mem_ctl;
	logic [IW-1:0]      rd_idx;
	logic [IW-1:0]      wr_idx;
	logic [ENTRY_W-1:0] wr_data;
	logic [ENTRY_W-1:0] rd_data;

	dat_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.device_address (device_address),
		.is_connectable (is_connectable),
		.is_public      (is_public),
		.mem_ctl        (mem_ctl),
		.rd_idx         (rd_idx),
		.wr_idx         (wr_idx),
		.wr_data        (wr_data),
		.rd_data        (rd_data),
		.strobe         (strobe),
		.status         (status),
		.entry_address  (entry_address),
		.connect_mark   (connect_mark),
		.public_mark    (public_mark),
		.entry_count    (entry_count)
	);

	dat_store #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_store (
		.clk     (clk),
		.mem_ctl (mem_ctl),
		.rd_idx  (rd_idx),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	// A clear reports on the very next cycle with an empty table.
	`DAT_ASSERT_NEXT(a_clear_empties, clk, arst_n, start && !busy && kind == K_CLEAR, strobe && status == ST_DONE && entry_count == '0)
	// The result cycle always finds the controller ready for the next request.
	`DAT_ASSERT_IMPLY(a_strobe_ready, clk, arst_n, strobe, !busy)
	// On a result that is not an entry, the entry fields are zero.
	`DAT_ASSERT_IMPLY(a_quiet_fields, clk, arst_n, strobe && status != ST_ENTRY, entry_address == '0 && connect_mark == '0 && public_mark == '0)

endmodule

@@ hw/rtl/dat_store.sv @@
module dat_store #(
	parameter int TABLE_DEPTH = dat_pkg::DEFAULT_DEPTH
) (
	input  logic                                clk,
	input  dat_pkg::mem_ctl_t                   mem_ctl,
	input  logic [$clog2(TABLE_DEPTH)-1:0]      rd_idx,
	input  logic [$clog2(TABLE_DEPTH)-1:0]      wr_idx,
	input  logic [dat_pkg::ENTRY_W-1:0]         wr_data,
	output logic [dat_pkg::ENTRY_W-1:0]         rd_data
);
	import dat_pkg::*;

	// Each entry holds the address followed by the connectable and public marks.
	logic [ENTRY_W-1:0] store_q [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			store_q[wr_idx] <= wr_data;
		end
		if (mem_ctl.rd_en) begin
			rd_data_q <= store_q[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/dat_ctrl.sv @@
module dat_ctrl #(
	parameter int TABLE_DEPTH = dat_pkg::DEFAULT_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [dat_pkg::KIND_W-1:0]          kind,
	input  logic [dat_pkg::ADDR_W-1:0]          device_address,
	input  logic                                is_connectable,
	input  logic                                is_public,
	output dat_pkg::mem_ctl_t                   mem_ctl,
	output logic [$clog2(TABLE_DEPTH)-1:0]      rd_idx,
	output logic [$clog2(TABLE_DEPTH)-1:0]      wr_idx,
	output logic [dat_pkg::ENTRY_W-1:0]         wr_data,
	input  logic [dat_pkg::ENTRY_W-1:0]         rd_data,
	output logic                                strobe,
	output logic [dat_pkg::STATUS_W-1:0]        status,
	output logic [dat_pkg::ADDR_W-1:0]          entry_address,
	output logic [dat_pkg::MARK_W-1:0]          connect_mark,
	output logic [dat_pkg::MARK_W-1:0]          public_mark,
	output logic [dat_pkg::COUNT_OUT_W-1:0]     entry_count
);
	import dat_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_FETCH = 3'b100
	} state_t;

	function automatic logic [MARK_W-1:0] mark_merge(input logic [MARK_W-1:0] old_mark,
			input logic seen);
		return (seen && old_mark == MARK_NO) ? MARK_BOTH : old_mark;
	endfunction

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      cursor_q;
	logic [CW-1:0]      idx_q;
	logic [IW-1:0]      idx_s1;
	logic               vld_s1;
	logic [ADDR_W-1:0]  req_addr_q;
	logic               req_conn_q;
	logic               req_pub_q;
	logic               strobe_q;
	status_t            status_q;
	logic [ADDR_W-1:0]  eaddr_q;
	logic [MARK_W-1:0]  cmark_q;
	logic [MARK_W-1:0]  pmark_q;

	logic               accept;
	logic               scan_issue;
	logic               hit;
	logic               miss;
	logic               table_full;
	logic               enum_ok;
	logic               fin;
	logic               fin_entry;
	status_t            fin_status;
	logic [ADDR_W-1:0]  rd_addr;
	logic [MARK_W-1:0]  rd_cmark;
	logic [MARK_W-1:0]  rd_pmark;

	assign {rd_addr, rd_cmark, rd_pmark} = rd_data;

	assign accept     = start && (state_q == S_IDLE);
	assign busy       = (state_q != S_IDLE);
	assign table_full = (count_q == CW'(TABLE_DEPTH));
	assign enum_ok    = (cursor_q < count_q);

	// The scan keeps one read in flight; the compare sees the entry read in the previous cycle.
	assign hit        = (state_q == S_SCAN) && vld_s1 && (rd_addr == req_addr_q);
	assign scan_issue = (state_q == S_SCAN) && (idx_q < count_q) && !hit;
	assign miss       = (state_q == S_SCAN) && !vld_s1 && (idx_q >= count_q);

	always_comb begin
		mem_ctl.rd_en = scan_issue || (accept && kind == K_NEXT && enum_ok);
		mem_ctl.wr_en = hit || (miss && !table_full);
		rd_idx        = scan_issue ? idx_q[IW-1:0] : cursor_q[IW-1:0];
		wr_idx        = hit ? idx_s1 : count_q[IW-1:0];
		if (hit) begin
			wr_data = {req_addr_q, mark_merge(rd_cmark, req_conn_q),
				mark_merge(rd_pmark, req_pub_q)};
		end else begin
			wr_data = {req_addr_q, req_conn_q ? MARK_YES : MARK_NO,
				req_pub_q ? MARK_YES : MARK_NO};
		end
	end

	always_comb begin
		fin        = 1'b0;
		fin_entry  = 1'b0;
		fin_status = ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (kind) inside
						K_CLEAR, K_RESTART: begin
							fin = 1'b1;
						end
						K_NEXT: begin
							if (!enum_ok) begin
								fin        = 1'b1;
								fin_status = ST_EXHAUSTED;
							end
						end
						K_ADD: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					fin        = 1'b1;
					fin_status = ST_PRESENT;
				end else if (miss) begin
					fin        = 1'b1;
					fin_status = table_full ? ST_FULL : ST_INSERTED;
				end
			end
			S_FETCH: begin
				fin        = 1'b1;
				fin_entry  = 1'b1;
				fin_status = ST_ENTRY;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			vld_s1   <= scan_issue;
			strobe_q <= fin;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (kind)
							K_CLEAR: begin
								count_q <= '0;
							end
							K_RESTART: begin
								cursor_q <= '0;
							end
							K_ADD: begin
								idx_q   <= '0;
								state_q <= S_SCAN;
							end
							K_NEXT: begin
								if (enum_ok) begin
									cursor_q <= cursor_q + 1'b1;
									state_q  <= S_FETCH;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (hit) begin
						state_q <= S_IDLE;
					end else if (miss) begin
						state_q <= S_IDLE;
						if (!table_full) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_addr_q <= device_address;
			req_conn_q <= is_connectable;
			req_pub_q  <= is_public;
		end
		idx_s1 <= idx_q[IW-1:0];
		if (fin) begin
			status_q <= fin_status;
			eaddr_q  <= fin_entry ? rd_addr : '0;
			cmark_q  <= fin_entry ? rd_cmark : MARK_NO;
			pmark_q  <= fin_entry ? rd_pmark : MARK_NO;
		end
	end

	assign strobe        = strobe_q;
	assign status        = status_q;
	assign entry_address = eaddr_q;
	assign connect_mark  = cmark_q;
	assign public_mark   = pmark_q;
	assign entry_count   = COUNT_OUT_W'(count_q);

endmodule

@@ tb/device_address_table_tb.sv @@
`timescale 1ns / 1ps

module device_address_table_tb;
	import dat_pkg::*;

	localparam int TABLE_DEPTH   = DEFAULT_DEPTH;
	localparam int RANDOM_ITEMS  = 1950;
	localparam int PHASE_LENGTH  = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int REPORT_LIMIT  = 10;

	typedef struct {
		kind_t              kind;
		logic [ADDR_W-1:0]  address;
		logic               connectable;
		logic               pub;
	} table_request_t;

	typedef struct {
		status_t                 status;
		logic [ADDR_W-1:0]       address;
		logic [MARK_W-1:0]       connect_mark;
		logic [MARK_W-1:0]       public_mark;
		logic [COUNT_OUT_W-1:0]  count;
	} table_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	kind_t                   kind = K_CLEAR;
	logic [ADDR_W-1:0]       device_address = '0;
	logic                    is_connectable = 1'b0;
	logic                    is_public = 1'b0;
	logic                    strobe;
	logic [STATUS_W-1:0]     status;
	logic [ADDR_W-1:0]       entry_address;
	logic [MARK_W-1:0]       connect_mark;
	logic [MARK_W-1:0]       public_mark;
	logic [COUNT_OUT_W-1:0]  entry_count;

	table_request_t  request_queue[$];
	table_result_t   expected_results[$];
	int              total_requests = 0;
	int              accepted_count = 0;
	int              mismatches = 0;
	int              stall_cycles = 0;

	// Shadow copy of the table, updated as each request is taken.
	logic [ADDR_W-1:0]  shadow_address[TABLE_DEPTH];
	logic [MARK_W-1:0]  shadow_connect[TABLE_DEPTH];
	logic [MARK_W-1:0]  shadow_public[TABLE_DEPTH];
	int                 shadow_count = 0;
	int                 shadow_cursor = 0;

	device_address_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.device_address(device_address),
		.is_connectable(is_connectable),
		.is_public     (is_public),
		.strobe        (strobe),
		.status        (status),
		.entry_address (entry_address),
		.connect_mark  (connect_mark),
		.public_mark   (public_mark),
		.entry_count   (entry_count)
	);

	always #10 clk = ~clk;

	function automatic logic [MARK_W-1:0] merge_mark(logic [MARK_W-1:0] old, logic seen_bit);
		if (seen_bit && old == MARK_NO)
			return MARK_BOTH;
		return old;
	endfunction

	function automatic table_result_t apply_to_shadow(table_request_t req);
		table_result_t res;
		bit found;
		res.status = ST_DONE;
		res.address = '0;
		res.connect_mark = '0;
		res.public_mark = '0;
		found = 1'b0;
		case (req.kind)
			K_CLEAR: begin
				shadow_count = 0;
			end
			K_ADD: begin
				for (int i = 0; i < shadow_count; i++) begin
					if (!found && shadow_address[i] == req.address) begin
						found = 1'b1;
						shadow_connect[i] = merge_mark(shadow_connect[i], req.connectable);
						shadow_public[i] = merge_mark(shadow_public[i], req.pub);
						res.status = ST_PRESENT;
					end
				end
				if (!found) begin
					if (shadow_count >= TABLE_DEPTH) begin
						res.status = ST_FULL;
					end else begin
						shadow_address[shadow_count] = req.address;
						shadow_connect[shadow_count] = req.connectable ? MARK_YES : MARK_NO;
						shadow_public[shadow_count] = req.pub ? MARK_YES : MARK_NO;
						shadow_count++;
						res.status = ST_INSERTED;
					end
				end
			end
			K_RESTART: begin
				shadow_cursor = 0;
			end
			default: begin
				if (shadow_cursor < shadow_count) begin
					res.address = shadow_address[shadow_cursor];
					res.connect_mark = shadow_connect[shadow_cursor];
					res.public_mark = shadow_public[shadow_cursor];
					shadow_cursor++;
					res.status = ST_ENTRY;
				end else begin
					res.status = ST_EXHAUSTED;
				end
			end
		endcase
		res.count = shadow_count[COUNT_OUT_W-1:0];
		return res;
	endfunction

	function automatic int sender_idle_pct(int sent);
		case ((sent / PHASE_LENGTH) % 4)
			1: return 59;
			3: return 17;
			default: return 0;
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] random_address();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[ADDR_W-1:0];
	endfunction

	task automatic queue_request(kind_t k, logic [ADDR_W-1:0] a, logic c, logic p);
		table_request_t req;
		req.kind = k;
		req.address = a;
		req.connectable = c;
		req.pub = p;
		request_queue.push_back(req);
	endtask

	task automatic queue_junk(kind_t k);
		queue_request(k, random_address(), 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// One burst of traffic: mostly a clear, a run of adds drawn from a growing set of
	// addresses, then a walk over the table; sometimes just random noise.
	task automatic queue_episode();
		logic [ADDR_W-1:0] seen[$];
		logic [ADDR_W-1:0] a;
		int n_adds;
		int n_next;
		int roll;
		bit fill;
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(1, 8))
				queue_junk(kind_t'($urandom_range(3)));
			return;
		end
		fill = ($urandom_range(99) < 25);
		if ($urandom_range(99) < 80)
			queue_junk(K_CLEAR);
		n_adds = fill ? $urandom_range(34, 45) : $urandom_range(1, 20);
		repeat (n_adds) begin
			if (seen.size() == 0 || $urandom_range(99) < 65) begin
				roll = $urandom_range(99);
				// Near misses differ from a stored address in a single bit.
				if (roll < 10 && seen.size() != 0)
					a = seen[$urandom_range(seen.size() - 1)] ^ (48'd1 << $urandom_range(ADDR_W - 1));
				else if (roll < 15)
					a = $urandom_range(1) ? '1 : '0;
				else
					a = random_address();
				seen.push_back(a);
			end else begin
				a = seen[$urandom_range(seen.size() - 1)];
			end
			queue_request(K_ADD, a, 1'($urandom_range(1)), 1'($urandom_range(1)));
			if ($urandom_range(99) < 8)
				queue_junk(K_NEXT);
		end
		if ($urandom_range(99) < 85)
			queue_junk(K_RESTART);
		n_next = (seen.size() < TABLE_DEPTH ? seen.size() : TABLE_DEPTH) + $urandom_range(0, 2);
		repeat (n_next) begin
			queue_junk(K_NEXT);
			if ($urandom_range(99) < 3)
				queue_junk(K_CLEAR);
		end
	endtask

	initial begin : stimulus
		int n_target;
		// Walk an empty table, then exercise mark merging at the address extremes.
		queue_request(K_NEXT, '1, 1'b1, 1'b1);
		queue_request(K_ADD, '0, 1'b0, 1'b0);
		queue_request(K_ADD, '1, 1'b1, 1'b1);
		queue_request(K_ADD, '0, 1'b1, 1'b0);
		queue_request(K_ADD, '0, 1'b1, 1'b1);
		queue_request(K_ADD, '1, 1'b0, 1'b0);
		queue_request(K_ADD, 48'hFFFF_FFFF_FFFE, 1'b0, 1'b1);
		queue_request(K_ADD, 48'h8000_0000_0000, 1'b1, 1'b0);
		queue_request(K_NEXT, '0, 1'b0, 1'b0);
		queue_request(K_NEXT, '0, 1'b0, 1'b0);
		// A clear leaves the cursor where it was, so the walk resumes part way in.
		queue_request(K_CLEAR, 48'h5A5A_5A5A_5A5A, 1'b1, 1'b1);
		queue_request(K_NEXT, '0, 1'b0, 1'b0);
		queue_request(K_ADD, 48'h0000_0000_0001, 1'b1, 1'b0);
		queue_request(K_ADD, 48'h1234_5678_9ABC, 1'b0, 1'b1);
		queue_request(K_ADD, 48'hA5A5_A5A5_A5A5, 1'b1, 1'b1);
		queue_request(K_NEXT, '0, 1'b0, 1'b0);
		queue_request(K_NEXT, '0, 1'b0, 1'b0);
		queue_request(K_RESTART, 48'hFFFF_0000_FFFF, 1'b1, 1'b1);
		queue_request(K_NEXT, '1, 1'b1, 1'b0);
		queue_request(K_CLEAR, '0, 1'b0, 1'b0);
		n_target = request_queue.size() + RANDOM_ITEMS;
		while (request_queue.size() < n_target)
			queue_episode();
		total_requests = request_queue.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (!(accepted_count == total_requests && expected_results.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			$display("%0d results never arrived", expected_results.size());
		if (mismatches == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : drive_requests
		table_request_t req;
		if (!arst_n) begin
			start <= 1'b0;
			kind <= K_CLEAR;
			device_address <= '0;
			is_connectable <= 1'b0;
			is_public <= 1'b0;
		end else begin
			if (start && !busy) begin
				req.kind = kind;
				req.address = device_address;
				req.connectable = is_connectable;
				req.pub = is_public;
				expected_results.push_back(apply_to_shadow(req));
				accepted_count++;
			end
			// A request stays on the ports until it is taken.
			if (!start || !busy) begin
				if (request_queue.size() != 0 &&
				    $urandom_range(99) >= sender_idle_pct(accepted_count)) begin
					req = request_queue.pop_front();
					kind <= req.kind;
					device_address <= req.address;
					is_connectable <= req.connectable;
					is_public <= req.pub;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		table_result_t want;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result with nothing outstanding: status %0d", $realtime, status);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status || entry_address !== want.address ||
				    connect_mark !== want.connect_mark || public_mark !== want.public_mark ||
				    entry_count !== want.count) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: mismatch: expected status %0d addr %h conn %0d pub %0d count %0d, got status %0d addr %h conn %0d pub %0d count %0d",
							$realtime, want.status, want.address, want.connect_mark,
							want.public_mark, want.count, status, entry_address,
							connect_mark, public_mark, entry_count);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/dat_pkg.sv
hw/rtl/dat_store.sv
hw/rtl/dat_ctrl.sv
hw/rtl/device_address_table.sv
tb/device_address_table_tb.sv
